// ===== design/position_inertia_filter_top_assert.svh =====
// Assertion macros for the position inertia filter top level
`ifndef POSITION_INERTIA_FILTER_TOP_ASSERT_SVH
`define POSITION_INERTIA_FILTER_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define PIF_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define PIF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define PIF_ASSERT_IMPL(label, ante, cons)
`define PIF_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== design/pif_pkg.sv =====
// Shared types, constants and helpers of the position inertia filter
package pif_pkg;

  localparam int SAMPLE_W   = 21;
  localparam int RADIUS_W   = 20;
  localparam int LEN_W      = 20;
  localparam int GAIN_W     = 16;
  localparam int PLIM_W     = 22;
  localparam int RLIM_W     = 20;
  localparam int PINERT_W   = 23;
  localparam int RINERT_W   = 21;
  localparam int REGION_W   = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 22;
  localparam int MUL_W      = 24;

  typedef logic signed [SAMPLE_W-1:0] dist_t;
  typedef logic [RADIUS_W-1:0]        radius_t;
  typedef logic [REGION_W-1:0]        region_t;
  typedef logic [GAIN_W-1:0]          gain_t;
  typedef logic signed [MUL_W-1:0]    mul_t;

  localparam logic [CFG_IDX_W-1:0] REG_STRIP_LEN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_RADIUS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_POS_GAIN    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_POS_IGAIN   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RAD_GAIN    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RAD_IGAIN   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_POS_ILIMIT  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_RAD_ILIMIT  = 3'd7;

  localparam logic [LEN_W-1:0]    RST_STRIP_LEN  = 20'd430000;
  localparam logic [RADIUS_W-1:0] RST_MAX_RADIUS = 20'd50000;
  localparam gain_t               RST_POS_GAIN   = 16'd9830;
  localparam gain_t               RST_POS_IGAIN  = 16'd3277;
  localparam gain_t               RST_RAD_GAIN   = 16'd9830;
  localparam gain_t               RST_RAD_IGAIN  = 16'd5243;
  localparam logic [PLIM_W-1:0]   RST_POS_ILIMIT = 22'd2000000;
  localparam logic [RLIM_W-1:0]   RST_RAD_ILIMIT = 20'd1000000;

  localparam int MIN_PRESENT_UM  = 1000;
  localparam int FRESH_RADIUS_UM = 10;
  localparam int RADIUS_MAX      = 2**RADIUS_W - 1;
  localparam int POS_MAX         = 2**(SAMPLE_W-1) - 1;
  localparam int POS_MIN         = -(2**(SAMPLE_W-1));

  localparam region_t REGION_OUT    = 2'd0;
  localparam region_t REGION_FIRST  = 2'd1;
  localparam region_t REGION_SECOND = 2'd2;
  localparam region_t REGION_LAST   = 2'd3;

  // Q0.16 product, floored
  function automatic mul_t gain_mul(input mul_t x, input gain_t g);
    logic signed [MUL_W+GAIN_W:0] prod;
    prod = x * $signed({1'b0, g});
    return prod[MUL_W+GAIN_W-1:GAIN_W];
  endfunction

endpackage

// ===== design/pif_if.sv =====
// Handshake channels of the position inertia filter
interface pif_in_if;
  import pif_pkg::*;
  logic  valid;
  logic  ready;
  dist_t sample_distance_um;
  modport source (output valid, output sample_distance_um, input ready);
  modport sink (input valid, input sample_distance_um, output ready);
endinterface

interface pif_out_if;
  import pif_pkg::*;
  logic    valid;
  logic    ready;
  dist_t   filtered_distance_um;
  radius_t glow_radius_um;
  region_t strip_region;
  modport source (output valid, output filtered_distance_um, output glow_radius_um,
                  output strip_region, input ready);
  modport sink (input valid, input filtered_distance_um, input glow_radius_um,
                input strip_region, output ready);
endinterface

// ===== design/position_inertia_filter_top.sv =====
// An accepted word waits in s1_sample_r, then is filtered into the output register.
// One word per cycle unless the output stalls; state updates in one step per word.
// Output register decouples the sides: a new word is taken while a result waits.
// Reset (rst_n low, synchronous) clears the filter state and valid flags and
// loads the register defaults; no clearing pass follows.
`include "position_inertia_filter_top_assert.svh"

module position_inertia_filter_top (
  input  logic                           clk,
  input  logic                           rst_n,
  pif_in_if.sink                         in_ch,
  pif_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [pif_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pif_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import pif_pkg::*;

  logic [LEN_W-1:0]    strip_len_r;
  radius_t             max_rad_r;
  gain_t               pos_gain_r;
  gain_t               pos_igain_r;
  gain_t               rad_gain_r;
  gain_t               rad_igain_r;
  logic [PLIM_W-1:0]   pos_ilim_r;
  logic [RLIM_W-1:0]   rad_ilim_r;

  logic                s1_valid_r;
  dist_t               s1_sample_r;
  logic                s1_adv;
  logic                commit;

  dist_t                      last_r, last_nxt;
  logic signed [PINERT_W-1:0] pos_inert_r, pos_inert_nxt;
  radius_t                    glow_r, glow_nxt;
  logic signed [RINERT_W-1:0] rad_inert_r, rad_inert_nxt;

  logic                out_valid_r;
  dist_t               out_pos_r;
  radius_t             out_rad_r;
  region_t             out_region_r;

  logic signed [SAMPLE_W:0]   d_ext;
  logic signed [SAMPLE_W:0]   len_ext;
  logic                       absent;
  logic                       fresh;

  radius_t                    target;
  logic signed [RADIUS_W:0]   r_err;
  logic signed [RINERT_W:0]   ri_sum;
  logic signed [RINERT_W:0]   ri_lim;
  mul_t                       r_sum;

  logic signed [SAMPLE_W:0]   p_err;
  logic signed [PINERT_W:0]   pi_sum;
  logic signed [PINERT_W:0]   pi_lim;
  logic signed [PINERT_W-1:0] pi_new;
  logic signed [MUL_W:0]      np_sum;
  dist_t                      pos_follow;

  logic [LEN_W+2:0]           p_x3;
  logic [LEN_W+2:0]           len_x1;
  logic [LEN_W+2:0]           len_x2;
  region_t                    region;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strip_len_r <= RST_STRIP_LEN;
      max_rad_r   <= RST_MAX_RADIUS;
      pos_gain_r  <= RST_POS_GAIN;
      pos_igain_r <= RST_POS_IGAIN;
      rad_gain_r  <= RST_RAD_GAIN;
      rad_igain_r <= RST_RAD_IGAIN;
      pos_ilim_r  <= RST_POS_ILIMIT;
      rad_ilim_r  <= RST_RAD_ILIMIT;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_STRIP_LEN:  strip_len_r <= cfg_wdata[LEN_W-1:0];
        REG_MAX_RADIUS: max_rad_r   <= cfg_wdata[RADIUS_W-1:0];
        REG_POS_GAIN:   pos_gain_r  <= cfg_wdata[GAIN_W-1:0];
        REG_POS_IGAIN:  pos_igain_r <= cfg_wdata[GAIN_W-1:0];
        REG_RAD_GAIN:   rad_gain_r  <= cfg_wdata[GAIN_W-1:0];
        REG_RAD_IGAIN:  rad_igain_r <= cfg_wdata[GAIN_W-1:0];
        REG_POS_ILIMIT: pos_ilim_r  <= cfg_wdata[PLIM_W-1:0];
        REG_RAD_ILIMIT: rad_ilim_r  <= cfg_wdata[RLIM_W-1:0];
        default: ;
      endcase
    end
  end

  assign s1_adv      = !out_valid_r || out_ch.ready;
  assign commit      = s1_valid_r && s1_adv;
  assign in_ch.ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_sample_r <= in_ch.sample_distance_um;
    end
  end

  always_comb begin
    d_ext   = (SAMPLE_W+1)'(s1_sample_r);
    len_ext = $signed({2'b00, strip_len_r});
    absent  = (d_ext > len_ext) || (d_ext < $signed((SAMPLE_W+1)'(MIN_PRESENT_UM)));
    fresh   = glow_r < RADIUS_W'(FRESH_RADIUS_UM);

    // radius fade toward target
    target = absent ? '0 : max_rad_r;
    r_err  = $signed({1'b0, target}) - $signed({1'b0, glow_r});
    ri_sum = (RINERT_W+1)'(rad_inert_r) + (RINERT_W+1)'(r_err);
    ri_lim = $signed({2'b00, rad_ilim_r});
    if (ri_sum > ri_lim) begin
      rad_inert_nxt = RINERT_W'(ri_lim);
    end else if (ri_sum < -ri_lim) begin
      rad_inert_nxt = RINERT_W'(-ri_lim);
    end else begin
      rad_inert_nxt = RINERT_W'(ri_sum);
    end
    r_sum = MUL_W'($signed({1'b0, glow_r})) + gain_mul(MUL_W'(r_err), rad_gain_r)
          + gain_mul(MUL_W'(rad_inert_nxt), rad_igain_r);
    if (r_sum < 0) begin
      glow_nxt = '0;
    end else if (r_sum > MUL_W'(RADIUS_MAX)) begin
      glow_nxt = RADIUS_W'(RADIUS_MAX);
    end else begin
      glow_nxt = r_sum[RADIUS_W-1:0];
    end

    // position follow
    p_err  = d_ext - (SAMPLE_W+1)'(last_r);
    pi_sum = (PINERT_W+1)'(pos_inert_r) + (PINERT_W+1)'(p_err);
    pi_lim = $signed({2'b00, pos_ilim_r});
    if (pi_sum > pi_lim) begin
      pi_new = PINERT_W'(pi_lim);
    end else if (pi_sum < -pi_lim) begin
      pi_new = PINERT_W'(-pi_lim);
    end else begin
      pi_new = PINERT_W'(pi_sum);
    end
    np_sum = (MUL_W+1)'(last_r) + (MUL_W+1)'(gain_mul(MUL_W'(p_err), pos_gain_r))
           + (MUL_W+1)'(gain_mul(MUL_W'(pi_new), pos_igain_r));
    if (np_sum > (MUL_W+1)'(POS_MAX)) begin
      pos_follow = SAMPLE_W'(POS_MAX);
    end else if (np_sum < (MUL_W+1)'(POS_MIN)) begin
      pos_follow = SAMPLE_W'(POS_MIN);
    end else begin
      pos_follow = SAMPLE_W'(np_sum);
    end

    if (absent) begin
      last_nxt      = last_r;
      pos_inert_nxt = '0;
    end else if (fresh) begin
      last_nxt      = s1_sample_r;
      pos_inert_nxt = pos_inert_r;
    end else begin
      last_nxt      = pos_follow;
      pos_inert_nxt = pi_new;
    end

    // region of the held or updated position
    p_x3   = (LEN_W+3)'(last_nxt[SAMPLE_W-2:0]) * (LEN_W+3)'(3);
    len_x1 = (LEN_W+3)'(strip_len_r);
    len_x2 = (LEN_W+3)'({strip_len_r, 1'b0});
    if (!(last_nxt > 0) || !((SAMPLE_W+1)'(last_nxt) < len_ext)) begin
      region = REGION_OUT;
    end else if (p_x3 <= len_x1) begin
      region = REGION_FIRST;
    end else if (p_x3 <= len_x2) begin
      region = REGION_SECOND;
    end else begin
      region = REGION_LAST;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r      <= '0;
      pos_inert_r <= '0;
      glow_r      <= '0;
      rad_inert_r <= '0;
    end else if (commit) begin
      last_r      <= last_nxt;
      pos_inert_r <= pos_inert_nxt;
      glow_r      <= glow_nxt;
      rad_inert_r <= rad_inert_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_pos_r    <= last_nxt;
      out_rad_r    <= glow_nxt;
      out_region_r <= region;
    end
  end

  assign out_ch.valid                = out_valid_r;
  assign out_ch.filtered_distance_um = out_pos_r;
  assign out_ch.glow_radius_um       = out_rad_r;
  assign out_ch.strip_region         = out_region_r;

  `PIF_ASSERT_NEXT(a_commit_shows, s1_valid_r && s1_adv, out_valid_r)
  `PIF_ASSERT_NEXT(a_absent_clears, s1_valid_r && s1_adv && absent, pos_inert_r == '0)
  `PIF_ASSERT_IMPL(a_region_pos, out_valid_r && (out_region_r != REGION_OUT), out_pos_r > 0)

endmodule
